// ----- rtl/axis_angle_rotation_matrix_top_assert.svh -----
// Assertion macros for the axis-angle rotation matrix block.
// Used by the checker; expects clk_i and rst_ni in the enclosing scope.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AARM_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aarm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define AARM_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aarm: next-cycle check failed");

`endif

// ----- rtl/aarm_pkg.sv -----
// Package for the axis-angle rotation matrix block.
// Word types, fixed-point constants and the CORDIC arctangent table; no dependencies.
package aarm_pkg;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] turn_angle;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] entry_00;
    logic signed [15:0] entry_01;
    logic signed [15:0] entry_02;
    logic signed [15:0] entry_10;
    logic signed [15:0] entry_11;
    logic signed [15:0] entry_12;
    logic signed [15:0] entry_20;
    logic signed [15:0] entry_21;
    logic signed [15:0] entry_22;
    logic               zero_axis;
  } out_word_t;

  // Angles in Q.30 radians.
  localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam int MAX_ITER    = 32;
  localparam int SQRT_STEPS  = 31;
  localparam int DIV_STEPS   = 16;

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  // Truncated Q.30 arctangent of 2^-idx.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/aarm_ifs.sv -----
// Stream interfaces for the axis-angle rotation matrix block.
// Depends on aarm_pkg for the word types.
interface aarm_in_if import aarm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aarm_out_if import aarm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/axis_angle_rotation_matrix_top.sv -----
// Axis-angle (Rodrigues) rotation matrix, fully pipelined: one word enters per cycle while the
// output is not stalled. The depth is set by the 31-stage square root that forms
// the axis length followed by the 16-stage restoring divider that normalizes the three
// components; the CORDIC sine/cosine chain (CORDIC_ITERATIONS stages, at most 32) runs beside
// them. A stalled output freezes the whole pipeline; a zero axis gives the identity and flags it.
// Depends on aarm_pkg and the aarm_in_if / aarm_out_if interfaces.
module axis_angle_rotation_matrix_top import aarm_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aarm_in_if.sink       src_i,
  aarm_out_if.source    res_o
);

  localparam int NIT   = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
  localparam int CHAIN = 1 + SQRT_STEPS + DIV_STEPS;
  localparam int DLY   = CHAIN - NIT;
  localparam int VLEN  = CHAIN + 4;

  typedef struct packed {
    logic [61:0]      n;
    logic [61:0]      res;
    logic [2:0][15:0] mag;
    logic [2:0]       sgn;
    logic             zero;
  } sqs_t;

  typedef struct packed {
    logic [30:0]      len;
    logic [2:0][46:0] rem;
    logic [2:0][15:0] q;
    logic [2:0]       sgn;
    logic             zero;
  } dvs_t;

  typedef struct packed {
    logic signed [33:0] sn;
    logic signed [33:0] t;
  } scs_t;

  function automatic logic signed [15:0] rnd_sat(input logic signed [66:0] v);
    logic signed [66:0] r;
    r = (v + 67'sd8796093022208) >>> 44;
    if (r > 67'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -67'sd32768) begin
      return 16'sh8000;
    end else begin
      return r[15:0];
    end
  endfunction

  // Global advance: everything moves unless a finished word is held at the output.
  logic            en;
  logic [VLEN-1:0] v_q;
  logic            out_v_q;
  out_word_t       out_q, out_d;

  assign en          = !out_v_q || res_o.ready;
  assign src_i.ready = en;
  assign res_o.valid = out_v_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q     <= {v_q[VLEN-2:0], src_i.valid};
      out_v_q <= v_q[VLEN-1];
    end
  end

  // Input stage: squares, magnitudes and angle range reduction.
  logic signed [15:0] ain [3];
  logic signed [31:0] sq_p [3];
  logic signed [16:0] a_ext [3];
  logic [30:0]        sq0_q [3];
  logic [15:0]        mag0_d [3], mag0_q [3];
  logic [2:0]         sgn0_q;
  logic signed [34:0] zw, zr;
  logic signed [33:0] z0_q;
  logic               zn_d, zn0_q;

  assign ain[0] = src_i.data.axis_x;
  assign ain[1] = src_i.data.axis_y;
  assign ain[2] = src_i.data.axis_z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq_p[c]   = ain[c] * ain[c];
      a_ext[c]  = 17'(ain[c]);
      mag0_d[c] = ain[c][15] ? 16'(-a_ext[c]) : 16'(a_ext[c]);
    end
    zw   = 35'(src_i.data.turn_angle) <<< 17;
    zr   = zw;
    zn_d = 1'b0;
    if (zw > ANG_HALF_PI) begin
      zr   = zw - ANG_PI;
      zn_d = 1'b1;
    end else if (zw < -ANG_HALF_PI) begin
      zr   = zw + ANG_PI;
      zn_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq0_q[c]  <= sq_p[c][30:0];
        mag0_q[c] <= mag0_d[c];
        sgn0_q[c] <= ain[c][15];
      end
      z0_q  <= zr[33:0];
      zn0_q <= zn_d;
    end
  end

  // Square root of the squared length, one result bit per stage.
  sqs_t        sq_d [SQRT_STEPS+1];
  sqs_t        sq_q [SQRT_STEPS+1];
  logic [31:0] sum_w;

  always_comb begin
    sum_w = 32'(sq0_q[0]) + 32'(sq0_q[1]) + 32'(sq0_q[2]);
    sq_d[0].n    = 62'(sum_w) << 28;
    sq_d[0].res  = '0;
    sq_d[0].zero = (sum_w == 32'd0);
    for (int c = 0; c < 3; c++) begin
      sq_d[0].mag[c] = mag0_q[c];
      sq_d[0].sgn[c] = sgn0_q[c];
    end
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      sq_d[k] = sq_q[k-1];
      if (sq_q[k-1].n >= sq_q[k-1].res + (62'd1 << (60 - 2 * (k - 1)))) begin
        sq_d[k].n   = sq_q[k-1].n - (sq_q[k-1].res + (62'd1 << (60 - 2 * (k - 1))));
        sq_d[k].res = (sq_q[k-1].res >> 1) + (62'd1 << (60 - 2 * (k - 1)));
      end else begin
        sq_d[k].res = sq_q[k-1].res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        sq_q[k] <= sq_d[k];
      end
    end
  end

  // Restoring division of each magnitude by the length, one quotient bit per stage.
  dvs_t dv_in [DIV_STEPS];
  dvs_t dv_d  [DIV_STEPS];
  dvs_t dv_q  [DIV_STEPS];

  always_comb begin
    dv_in[0].len  = sq_q[SQRT_STEPS].res[30:0];
    dv_in[0].sgn  = sq_q[SQRT_STEPS].sgn;
    dv_in[0].zero = sq_q[SQRT_STEPS].zero;
    dv_in[0].q    = '0;
    for (int c = 0; c < 3; c++) begin
      dv_in[0].rem[c] = 47'(sq_q[SQRT_STEPS].mag[c]) << 29;
    end
    for (int j = 1; j < DIV_STEPS; j++) begin
      dv_in[j] = dv_q[j-1];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      dv_d[j] = dv_in[j];
      for (int c = 0; c < 3; c++) begin
        if (dv_in[j].rem[c] >= (47'(dv_in[j].len) << (DIV_STEPS - 1 - j))) begin
          dv_d[j].rem[c] = dv_in[j].rem[c] - (47'(dv_in[j].len) << (DIV_STEPS - 1 - j));
          dv_d[j].q[c][DIV_STEPS-1-j] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  // CORDIC rotation chain, one iteration per stage.
  logic signed [33:0] cin_x [NIT], cin_y [NIT], cin_z [NIT];
  logic               cin_n [NIT];
  logic signed [33:0] cx_d [NIT], cy_d [NIT], cz_d [NIT];
  logic signed [33:0] cx_q [NIT], cy_q [NIT], cz_q [NIT];
  logic               cn_q [NIT];

  always_comb begin
    cin_x[0] = CORDIC_GAIN;
    cin_y[0] = '0;
    cin_z[0] = z0_q;
    cin_n[0] = zn0_q;
    for (int k = 1; k < NIT; k++) begin
      cin_x[k] = cx_q[k-1];
      cin_y[k] = cy_q[k-1];
      cin_z[k] = cz_q[k-1];
      cin_n[k] = cn_q[k-1];
    end
    for (int k = 0; k < NIT; k++) begin
      if (!cin_z[k][33]) begin
        cx_d[k] = cin_x[k] - (cin_y[k] >>> k);
        cy_d[k] = cin_y[k] + (cin_x[k] >>> k);
        cz_d[k] = cin_z[k] - $signed({2'b00, atan_q30(5'(k))});
      end else begin
        cx_d[k] = cin_x[k] + (cin_y[k] >>> k);
        cy_d[k] = cin_y[k] - (cin_x[k] >>> k);
        cz_d[k] = cin_z[k] + $signed({2'b00, atan_q30(5'(k))});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NIT; k++) begin
        cx_q[k] <= cx_d[k];
        cy_q[k] <= cy_d[k];
        cz_q[k] <= cz_d[k];
        cn_q[k] <= cin_n[k];
      end
    end
  end

  // Sine and one minus cosine, delayed to meet the normalized axis.
  scs_t               sc_d [DLY+1];
  scs_t               sc_q [DLY+1];
  logic signed [33:0] cs_w;

  always_comb begin
    cs_w       = cn_q[NIT-1] ? -cx_q[NIT-1] : cx_q[NIT-1];
    sc_d[0].sn = cn_q[NIT-1] ? -cy_q[NIT-1] : cy_q[NIT-1];
    sc_d[0].t  = 34'sd1073741824 - cs_w;
    for (int k = 1; k <= DLY; k++) begin
      sc_d[k] = sc_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= DLY; k++) begin
        sc_q[k] <= sc_d[k];
      end
    end
  end

  // Round the quotients and restore the component signs.
  logic [16:0]        qr [3];
  logic signed [16:0] u_d [3], u_q [3];
  logic               u_zero_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qr[c]  = (17'(dv_q[DIV_STEPS-1].q[c]) + 17'd1) >> 1;
      u_d[c] = dv_q[DIV_STEPS-1].sgn[c] ? -$signed(qr[c]) : $signed(qr[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        u_q[c] <= u_d[c];
      end
      u_zero_q <= dv_q[DIV_STEPS-1].zero;
    end
  end

  // First products: axis outer products and axis times sine.
  logic signed [33:0] uu_q [6];
  logic signed [50:0] us_q [3];
  logic signed [33:0] t1_q;
  logic               p1_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      uu_q[0] <= u_q[0] * u_q[0];
      uu_q[1] <= u_q[1] * u_q[1];
      uu_q[2] <= u_q[2] * u_q[2];
      uu_q[3] <= u_q[0] * u_q[1];
      uu_q[4] <= u_q[0] * u_q[2];
      uu_q[5] <= u_q[1] * u_q[2];
      for (int c = 0; c < 3; c++) begin
        us_q[c] <= u_q[c] * sc_q[DLY].sn;
      end
      t1_q      <= sc_q[DLY].t;
      p1_zero_q <= u_zero_q;
    end
  end

  // Second products: terms scaled by one minus cosine; the axis-sine terms are only shifted into place.
  logic signed [33:0] dg_w [3];
  logic signed [64:0] dg_q [3], of_q [3], ss_q [3];
  logic               p2_zero_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      dg_w[c] = uu_q[c] - 34'sd268435456;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dg_q[c] <= t1_q * $signed(dg_w[c][30:0]);
        of_q[c] <= t1_q * $signed(uu_q[3+c][30:0]);
        ss_q[c] <= 65'(us_q[c]) <<< 14;
      end
      p2_zero_q <= p1_zero_q;
    end
  end

  // Final sums, rounding to Q2.14 with saturation, identity for a zero axis.
  localparam logic signed [66:0] ONE_Q58 = 67'sd1 <<< 58;

  always_comb begin
    if (p2_zero_q) begin
      out_d          = '0;
      out_d.entry_00 = Q14_ONE;
      out_d.entry_11 = Q14_ONE;
      out_d.entry_22 = Q14_ONE;
      out_d.zero_axis = 1'b1;
    end else begin
      out_d.entry_00 = rnd_sat(ONE_Q58 + 67'(dg_q[0]));
      out_d.entry_01 = rnd_sat(67'(ss_q[2]) + 67'(of_q[0]));
      out_d.entry_02 = rnd_sat(-67'(ss_q[1]) + 67'(of_q[1]));
      out_d.entry_10 = rnd_sat(-67'(ss_q[2]) + 67'(of_q[0]));
      out_d.entry_11 = rnd_sat(ONE_Q58 + 67'(dg_q[1]));
      out_d.entry_12 = rnd_sat(67'(ss_q[0]) + 67'(of_q[2]));
      out_d.entry_20 = rnd_sat(67'(ss_q[1]) + 67'(of_q[1]));
      out_d.entry_21 = rnd_sat(-67'(ss_q[0]) + 67'(of_q[2]));
      out_d.entry_22 = rnd_sat(ONE_Q58 + 67'(dg_q[2]));
      out_d.zero_axis = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- rtl/aarm_checker.sv -----
// Port-level checker for the axis-angle rotation matrix block, bound to the top level.
// Depends on aarm_pkg and the assertion macro header.
`include "axis_angle_rotation_matrix_top_assert.svh"

module aarm_checker import aarm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_word_t out_word_i
);

  // A held result word stays put until it is taken.
  `AARM_AST_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_word_i))

  // Input back-pressure only comes from a result word waiting at the output.
  `AARM_AST_IMP(a_ready_cause, !in_ready_i, out_valid_i && !out_ready_i)

  // A zero axis gives ones on the diagonal.
  `AARM_AST_IMP(a_zero_diag, out_valid_i && out_word_i.zero_axis, out_word_i.entry_00 == 16'sd16384 && out_word_i.entry_11 == 16'sd16384 && out_word_i.entry_22 == 16'sd16384)

  // A zero axis gives zeros off the diagonal.
  `AARM_AST_IMP(a_zero_off, out_valid_i && out_word_i.zero_axis, out_word_i.entry_01 == 16'sd0 && out_word_i.entry_02 == 16'sd0 && out_word_i.entry_10 == 16'sd0 && out_word_i.entry_12 == 16'sd0 && out_word_i.entry_20 == 16'sd0 && out_word_i.entry_21 == 16'sd0)

endmodule

bind axis_angle_rotation_matrix_top aarm_checker u_aarm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (src_i.valid),
  .in_ready_i  (src_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_word_i  (res_o.data)
);
